// File: rtl/texture_coordinate_projection_defines.svh
// Assertion helpers for the texture coordinate projection block.
// Each expects clk and rst_n in scope.
`ifndef TEXTURE_COORDINATE_PROJECTION_DEFINES_SVH
`define TEXTURE_COORDINATE_PROJECTION_DEFINES_SVH

// same-cycle implication
`define TCP_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCP_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tcp_pkg.sv
package tcp_pkg;

    // angle engine
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_XW    = 44;
    localparam int CORDIC_ZW    = 34;
    localparam int ANG_BITS     = 41;
    localparam int SPH_BITS     = 29;

    // square root
    localparam int SQ_W     = 60;
    localparam int SQ_STEPS = 30;
    localparam int SQ_RES_W = 31;

    // angles in 2^-32 turn
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    // projection modes
    localparam logic [2:0] MODE_XY  = 3'd0;
    localparam logic [2:0] MODE_XZ  = 3'd1;
    localparam logic [2:0] MODE_YZ  = 3'd2;
    localparam logic [2:0] MODE_CYL = 3'd3;
    localparam logic [2:0] MODE_SPH = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_MIN_X = 3'd1;
    localparam logic [2:0] REG_MAX_X = 3'd2;
    localparam logic [2:0] REG_MIN_Y = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MIN_Z = 3'd5;
    localparam logic [2:0] REG_MAX_Z = 3'd6;

    typedef enum logic [1:0] {
        SPEC_DIV,
        SPEC_ZERO,
        SPEC_ONE
    } spec_t;

    typedef struct packed {
        logic u_zero;
        logic u_qtr;
        logic x_neg;
        logic ny_neg;
    } uflag_t;

    typedef struct packed {
        logic s_zero;
        logic dy_neg;
        logic r_zero;
        logic ay_zero;
    } vflag_t;

    typedef struct packed {
        spec_t spec_u;
        spec_t spec_v;
    } pspec_t;

endpackage

// File: rtl/tcp_div_cell.sv
// One restoring division step: one quotient bit per cell.
module tcp_div_cell #(
    parameter int RW  = 34,
    parameter int QW  = 16,
    parameter int SBW = 4
) (
    input  logic           clk,
    input  logic           en,
    input  logic [RW-1:0]  r_in,
    input  logic [RW-1:0]  den_in,
    input  logic [QW-1:0]  q_in,
    input  logic [SBW-1:0] sb_in,
    output logic [RW-1:0]  r_out,
    output logic [RW-1:0]  den_out,
    output logic [QW-1:0]  q_out,
    output logic [SBW-1:0] sb_out
);

    logic [RW-1:0]  r2;
    logic           ge;
    logic [RW-1:0]  r_reg;
    logic [RW-1:0]  den_reg;
    logic [QW-1:0]  q_reg;
    logic [SBW-1:0] sb_reg;

    assign r2 = {r_in[RW-2:0], 1'b0};
    assign ge = (r2 >= den_in);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= ge ? (r2 - den_in) : r2;
            den_reg <= den_in;
            q_reg   <= {q_in[QW-2:0], ge};
            sb_reg  <= sb_in;
        end
    end

    assign r_out   = r_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;
    assign sb_out  = sb_reg;

endmodule

// File: rtl/tcp_norm_cell.sv
// One step of a joint leading-one normalizer: shift all lanes left by SH
// when the top SH bits of every lane are clear.
module tcp_norm_cell #(
    parameter int W     = 41,
    parameter int LANES = 2,
    parameter int SH    = 32,
    parameter int SBW   = 4
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [LANES-1:0][W-1:0]   a_in,
    input  logic [SBW-1:0]            sb_in,
    output logic [LANES-1:0][W-1:0]   a_out,
    output logic [SBW-1:0]            sb_out
);

    logic                    top_any;
    logic [LANES-1:0][W-1:0] a_next;
    logic [LANES-1:0][W-1:0] a_reg;
    logic [SBW-1:0]          sb_reg;

    always_comb
    begin
        top_any = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            top_any = top_any | (|a_in[l][W-1 -: SH]);
        end
        for (int l = 0; l < LANES; l++)
        begin
            a_next[l] = top_any ? a_in[l] : (a_in[l] << SH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_next;
            sb_reg <= sb_in;
        end
    end

    assign a_out  = a_reg;
    assign sb_out = sb_reg;

endmodule

// File: rtl/tcp_cordic_cell.sv
// One vectoring CORDIC rotation; drives y toward zero, accumulates angle.
module tcp_cordic_cell
    import tcp_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SBW  = 4
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [CORDIC_XW-1:0] x_in,
    input  logic signed [CORDIC_XW-1:0] y_in,
    input  logic signed [CORDIC_ZW-1:0] z_in,
    input  logic [SBW-1:0]              sb_in,
    output logic signed [CORDIC_XW-1:0] x_out,
    output logic signed [CORDIC_XW-1:0] y_out,
    output logic signed [CORDIC_ZW-1:0] z_out,
    output logic [SBW-1:0]              sb_out
);

    localparam logic signed [CORDIC_ZW-1:0] ATAN = CORDIC_ZW'(ATAN_TURNS[STEP]);

    logic signed [CORDIC_XW-1:0] xs;
    logic signed [CORDIC_XW-1:0] ys;
    logic signed [CORDIC_XW-1:0] x_reg;
    logic signed [CORDIC_XW-1:0] y_reg;
    logic signed [CORDIC_ZW-1:0] z_reg;
    logic [SBW-1:0]              sb_reg;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[CORDIC_XW-1])
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + ATAN;
            end
            else
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - ATAN;
            end
            sb_reg <= sb_in;
        end
    end

    assign x_out  = x_reg;
    assign y_out  = y_reg;
    assign z_out  = z_reg;
    assign sb_out = sb_reg;

endmodule

// File: rtl/tcp_sqrt_cell.sv
// One digit of a bit-pair integer square root.
module tcp_sqrt_cell
    import tcp_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SBW  = 31
) (
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   n_in,
    input  logic [SQ_W-1:0]   res_in,
    input  logic [SBW-1:0]    sb_in,
    output logic [SQ_W-1:0]   n_out,
    output logic [SQ_W-1:0]   res_out,
    output logic [SBW-1:0]    sb_out
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

    logic [SQ_W-1:0] trial;
    logic            ge;
    logic [SQ_W-1:0] n_reg;
    logic [SQ_W-1:0] res_reg;
    logic [SBW-1:0]  sb_reg;

    assign trial = res_in + BIT;
    assign ge    = (n_in >= trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= ge ? (n_in - trial) : n_in;
            res_reg <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
            sb_reg  <= sb_in;
        end
    end

    assign n_out   = n_reg;
    assign res_out = res_reg;
    assign sb_out  = sb_reg;

endmodule

// File: rtl/texture_coordinate_projection.sv
// Texture coordinate projection. Each vertex beat (pos_x/y/z, signed Q16.16)
// yields one result beat: tex_u, tex_v as unsigned Q1.UV_FRAC_BITS and a
// mode_unsupported flag. Modes: XY, XZ, YZ planar fractions of the
// configured box (clamped to [0,1], zero for an empty or inverted extent),
// cylindrical (u = angle of atan2(-dz,dx) about the box center in turns,
// v = planar Y) and spherical (same u, v = 1/2 + asin(dy/|d|)/pi). Modes 5-7
// give 0,0 with the flag set. The block takes one beat per clock while
// in_stall is low and holds many beats in flight; the spherical path is
// the longest: normalizer, squares, 30-step square root, second normalizer
// and a 28-stage CORDIC. Every stage advances together; when the output
// register is full and stalled, input is still taken until the last pipeline
// stage holds a beat. Registers are to be written through the cfg port only
// while no beat is in flight; the user must ensure this, as the block does
// not enforce it. Index 7 is ignored.
`include "texture_coordinate_projection_defines.svh"

module texture_coordinate_projection
    import tcp_pkg::*;
#(
    parameter int COORD_WIDTH  = 32,
    parameter int UV_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [2:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [UV_FRAC_BITS:0]         tex_u,
    output logic [UV_FRAC_BITS:0]         tex_v,
    output logic                          mode_unsupported
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = UV_FRAC_BITS;
    localparam int DW = CW + 3;                 // 2*pos - min - max
    localparam int MW = CW + 2;                 // |d|
    localparam int RW = CW + 2;                 // divider remainder
    localparam int NW = (MW > ANG_BITS) ? MW : ANG_BITS;
    localparam int NS = $clog2(NW);
    localparam int LU = NS + 30;                // u angle ready
    localparam int LS = 2 * NS + 62;            // spherical v ready (last stage)
    localparam int DU = LS - LU;
    localparam int DP = LS - F;

    localparam logic [32:0] HALF_T  = 33'h0_8000_0000;
    localparam logic [32:0] FULL_T  = 33'h1_0000_0000;
    localparam logic [32:0] ROUND_T = 33'(1) << (31 - F);
    localparam logic signed [CORDIC_ZW-1:0] Q_Z = CORDIC_ZW'(QUARTER_TURN);

    // ---------------- configuration ----------------
    logic [2:0]           mode_reg;
    logic signed [CW-1:0] min_x_reg, max_x_reg;
    logic signed [CW-1:0] min_y_reg, max_y_reg;
    logic signed [CW-1:0] min_z_reg, max_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_XY;
            min_x_reg <= '0;
            max_x_reg <= '0;
            min_y_reg <= '0;
            max_y_reg <= '0;
            min_z_reg <= '0;
            max_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[2:0];
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_MAX_Z: max_z_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    // All stages move together. The pipe may move whenever the output
    // register can load, or the last stage is empty (a bubble drops out).
    logic [LS:0] vld_reg;
    logic        out_valid_reg;
    logic        out_take;
    logic        adv;

    assign out_take = !out_valid_reg || !out_stall;
    assign adv      = out_take || !vld_reg[LS];
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LS-1:0], in_valid};
        end
    end

    // ---------------- stage A: center offsets, planar setup ----------------
    function automatic spec_t plan_spec(input logic signed [CW-1:0] p,
                                        input logic signed [CW-1:0] lo,
                                        input logic signed [CW-1:0] hi);
        spec_t s;
        if (hi <= lo || p <= lo)
            s = SPEC_ZERO;
        else if (p >= hi)
            s = SPEC_ONE;
        else
            s = SPEC_DIV;
        return s;
    endfunction

    logic signed [CW-1:0] pu, lu, hu, pv, lv, hv;

    always_comb
    begin
        case (mode_reg)
            MODE_YZ:
            begin
                pu = pos_z; lu = min_z_reg; hu = max_z_reg;
            end
            default:
            begin
                pu = pos_x; lu = min_x_reg; hu = max_x_reg;
            end
        endcase
        case (mode_reg)
            MODE_XZ:
            begin
                pv = pos_z; lv = min_z_reg; hv = max_z_reg;
            end
            default:
            begin
                pv = pos_y; lv = min_y_reg; hv = max_y_reg;
            end
        endcase
    end

    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic [RW-1:0]        ru_reg, du_reg, rv_reg, dv_reg;
    pspec_t               pspec_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= (DW'(pos_x) <<< 1) - DW'(min_x_reg) - DW'(max_x_reg);
            dy_reg <= (DW'(pos_y) <<< 1) - DW'(min_y_reg) - DW'(max_y_reg);
            dz_reg <= (DW'(pos_z) <<< 1) - DW'(min_z_reg) - DW'(max_z_reg);
            ru_reg <= RW'(pu) - RW'(lu);
            du_reg <= RW'(hu) - RW'(lu);
            rv_reg <= RW'(pv) - RW'(lv);
            dv_reg <= RW'(hv) - RW'(lv);
            pspec_reg.spec_u <= plan_spec(pu, lu, hu);
            pspec_reg.spec_v <= plan_spec(pv, lv, hv);
        end
    end

    // ---------------- planar dividers: one bit per cell ----------------
    logic [RW-1:0]  pu_r [F+1];
    logic [RW-1:0]  pu_d [F+1];
    logic [F-1:0]   pu_q [F+1];
    logic [RW-1:0]  pv_r [F+1];
    logic [RW-1:0]  pv_d [F+1];
    logic [F-1:0]   pv_q [F+1];
    logic [3:0]     pp_sb [F+1];
    logic [3:0]     pq_sb [F+1];

    assign pu_r[0]  = ru_reg;
    assign pu_d[0]  = du_reg;
    assign pu_q[0]  = '0;
    assign pv_r[0]  = rv_reg;
    assign pv_d[0]  = dv_reg;
    assign pv_q[0]  = '0;
    assign pp_sb[0] = pspec_reg;
    assign pq_sb[0] = pspec_reg;

    for (genvar k = 0; k < F; k++)
    begin : g_div
        tcp_div_cell #(.RW(RW), .QW(F), .SBW(4)) u_div_u (
            .clk     (clk),
            .en      (adv),
            .r_in    (pu_r[k]),
            .den_in  (pu_d[k]),
            .q_in    (pu_q[k]),
            .sb_in   (pp_sb[k]),
            .r_out   (pu_r[k+1]),
            .den_out (pu_d[k+1]),
            .q_out   (pu_q[k+1]),
            .sb_out  (pp_sb[k+1])
        );
        tcp_div_cell #(.RW(RW), .QW(F), .SBW(4)) u_div_v (
            .clk     (clk),
            .en      (adv),
            .r_in    (pv_r[k]),
            .den_in  (pv_d[k]),
            .q_in    (pv_q[k]),
            .sb_in   (pq_sb[k]),
            .r_out   (pv_r[k+1]),
            .den_out (pv_d[k+1]),
            .q_out   (pv_q[k+1]),
            .sb_out  (pq_sb[k+1])
        );
    end

    // planar results wait for the angle paths
    typedef struct packed {
        logic [F-1:0] qu;
        logic [F-1:0] qv;
        pspec_t       spec;
    } plan_t;

    plan_t pd_reg [DP];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd_reg[0].qu   <= pu_q[F];
            pd_reg[0].qv   <= pv_q[F];
            pd_reg[0].spec <= pp_sb[F];
            for (int k = 1; k < DP; k++)
            begin
                pd_reg[k] <= pd_reg[k-1];
            end
        end
    end

    // ---------------- stage M: magnitudes and angle flags ----------------
    function automatic logic [NW-1:0] mag_of(input logic signed [DW-1:0] d);
        logic [DW-1:0] a;
        a = d[DW-1] ? -d : d;
        return NW'(a[MW-1:0]);
    endfunction

    logic [NW-1:0] ax_reg, ay_reg, az_reg;
    uflag_t        uf_m_reg;
    logic          s_zero_m_reg;
    logic          dy_neg_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg          <= mag_of(dx_reg);
            ay_reg          <= mag_of(dy_reg);
            az_reg          <= mag_of(dz_reg);
            uf_m_reg.u_zero <= (dz_reg == '0);
            uf_m_reg.u_qtr  <= (dx_reg == '0);
            uf_m_reg.x_neg  <= dx_reg[DW-1];
            uf_m_reg.ny_neg <= !dz_reg[DW-1] && (dz_reg != '0);
            s_zero_m_reg    <= (dx_reg == '0) && (dy_reg == '0) && (dz_reg == '0);
            dy_neg_m_reg    <= dy_reg[DW-1];
        end
    end

    // ---------------- u angle: normalize, CORDIC ----------------
    logic [1:0][NW-1:0] un_a  [NS+1];
    logic [3:0]         un_sb [NS+1];

    assign un_a[0][0] = ax_reg;
    assign un_a[0][1] = az_reg;
    assign un_sb[0]   = uf_m_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_unorm
        tcp_norm_cell #(.W(NW), .LANES(2), .SH(1 << (NS - 1 - k)), .SBW(4)) u_norm (
            .clk    (clk),
            .en     (adv),
            .a_in   (un_a[k]),
            .sb_in  (un_sb[k]),
            .a_out  (un_a[k+1]),
            .sb_out (un_sb[k+1])
        );
    end

    logic signed [CORDIC_XW-1:0] cu_x  [CORDIC_STEPS+1];
    logic signed [CORDIC_XW-1:0] cu_y  [CORDIC_STEPS+1];
    logic signed [CORDIC_ZW-1:0] cu_z  [CORDIC_STEPS+1];
    logic [3:0]                  cu_sb [CORDIC_STEPS+1];

    assign cu_x[0]  = {{(CORDIC_XW - ANG_BITS){1'b0}}, un_a[NS][0][NW-1 -: ANG_BITS]};
    assign cu_y[0]  = {{(CORDIC_XW - ANG_BITS){1'b0}}, un_a[NS][1][NW-1 -: ANG_BITS]};
    assign cu_z[0]  = '0;
    assign cu_sb[0] = un_sb[NS];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_ucordic
        tcp_cordic_cell #(.STEP(k), .SBW(4)) u_cordic (
            .clk    (clk),
            .en     (adv),
            .x_in   (cu_x[k]),
            .y_in   (cu_y[k]),
            .z_in   (cu_z[k]),
            .sb_in  (cu_sb[k]),
            .x_out  (cu_x[k+1]),
            .y_out  (cu_y[k+1]),
            .z_out  (cu_z[k+1]),
            .sb_out (cu_sb[k+1])
        );
    end

    function automatic logic [30:0] ang_clamp(input logic signed [CORDIC_ZW-1:0] z);
        logic [30:0] t;
        if (z[CORDIC_ZW-1])
            t = '0;
        else if (z > Q_Z)
            t = QUARTER_TURN[30:0];
        else
            t = z[30:0];
        return t;
    endfunction

    // u: first-quadrant angle folded into the full turn, rounded, wrapped
    uflag_t       uf_c;
    logic [30:0]  u_th;
    logic [32:0]  u_a;
    logic [32:0]  u_sum;
    logic [F-1:0] u_ang_reg;

    assign uf_c = cu_sb[CORDIC_STEPS];

    always_comb
    begin
        if (uf_c.u_zero)
            u_th = '0;
        else if (uf_c.u_qtr)
            u_th = QUARTER_TURN[30:0];
        else
            u_th = ang_clamp(cu_z[CORDIC_STEPS]);
        case ({uf_c.x_neg, uf_c.ny_neg})
            2'b00:   u_a = 33'(u_th);
            2'b10:   u_a = HALF_T - 33'(u_th);
            2'b11:   u_a = HALF_T + 33'(u_th);
            default: u_a = FULL_T - 33'(u_th);
        endcase
        u_sum = {1'b0, u_a[31:0]} + ROUND_T;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_ang_reg <= u_sum[32-F +: F];
        end
    end

    logic [F-1:0] ud_reg [DU];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ud_reg[0] <= u_ang_reg;
            for (int k = 1; k < DU; k++)
            begin
                ud_reg[k] <= ud_reg[k-1];
            end
        end
    end

    // ---------------- spherical v ----------------
    logic [2:0][NW-1:0] sn_a  [NS+1];
    logic [1:0]         sn_sb [NS+1];

    assign sn_a[0][0] = ax_reg;
    assign sn_a[0][1] = ay_reg;
    assign sn_a[0][2] = az_reg;
    assign sn_sb[0]   = {s_zero_m_reg, dy_neg_m_reg};

    for (genvar k = 0; k < NS; k++)
    begin : g_snorm
        tcp_norm_cell #(.W(NW), .LANES(3), .SH(1 << (NS - 1 - k)), .SBW(2)) u_norm (
            .clk    (clk),
            .en     (adv),
            .a_in   (sn_a[k]),
            .sb_in  (sn_sb[k]),
            .a_out  (sn_a[k+1]),
            .sb_out (sn_sb[k+1])
        );
    end

    logic [SPH_BITS-1:0]   sx, sy, sz;
    logic [2*SPH_BITS-1:0] sqx_reg, sqz_reg;
    logic [SPH_BITS-1:0]   ay_sq_reg, ay_add_reg;
    logic [1:0]            sf_sq_reg, sf_add_reg;
    logic [SQ_W-1:0]       n_add_reg;

    assign sx = sn_a[NS][0][NW-1 -: SPH_BITS];
    assign sy = sn_a[NS][1][NW-1 -: SPH_BITS];
    assign sz = sn_a[NS][2][NW-1 -: SPH_BITS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg    <= sx * sx;
            sqz_reg    <= sz * sz;
            ay_sq_reg  <= sy;
            sf_sq_reg  <= sn_sb[NS];
            n_add_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqz_reg);
            ay_add_reg <= ay_sq_reg;
            sf_add_reg <= sf_sq_reg;
        end
    end

    localparam int SQ_SBW = 2 + SPH_BITS;

    logic [SQ_W-1:0]   sq_n   [SQ_STEPS+1];
    logic [SQ_W-1:0]   sq_res [SQ_STEPS+1];
    logic [SQ_SBW-1:0] sq_sb  [SQ_STEPS+1];

    assign sq_n[0]   = n_add_reg;
    assign sq_res[0] = '0;
    assign sq_sb[0]  = {sf_add_reg, ay_add_reg};

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        tcp_sqrt_cell #(.STEP(k), .SBW(SQ_SBW)) u_sqrt (
            .clk     (clk),
            .en      (adv),
            .n_in    (sq_n[k]),
            .res_in  (sq_res[k]),
            .sb_in   (sq_sb[k]),
            .n_out   (sq_n[k+1]),
            .res_out (sq_res[k+1]),
            .sb_out  (sq_sb[k+1])
        );
    end

    logic [SQ_RES_W-1:0] r_len;
    logic [SPH_BITS-1:0] ay_len;
    vflag_t              vf_in;

    assign r_len         = sq_res[SQ_STEPS][SQ_RES_W-1:0];
    assign ay_len        = sq_sb[SQ_STEPS][SPH_BITS-1:0];
    assign vf_in.s_zero  = sq_sb[SQ_STEPS][SQ_SBW-1];
    assign vf_in.dy_neg  = sq_sb[SQ_STEPS][SQ_SBW-2];
    assign vf_in.r_zero  = (r_len == '0);
    assign vf_in.ay_zero = (ay_len == '0);

    logic [1:0][NW-1:0] vn_a  [NS+1];
    logic [3:0]         vn_sb [NS+1];

    assign vn_a[0][0] = NW'(r_len);
    assign vn_a[0][1] = NW'(ay_len);
    assign vn_sb[0]   = vf_in;

    for (genvar k = 0; k < NS; k++)
    begin : g_vnorm
        tcp_norm_cell #(.W(NW), .LANES(2), .SH(1 << (NS - 1 - k)), .SBW(4)) u_norm (
            .clk    (clk),
            .en     (adv),
            .a_in   (vn_a[k]),
            .sb_in  (vn_sb[k]),
            .a_out  (vn_a[k+1]),
            .sb_out (vn_sb[k+1])
        );
    end

    logic signed [CORDIC_XW-1:0] cv_x  [CORDIC_STEPS+1];
    logic signed [CORDIC_XW-1:0] cv_y  [CORDIC_STEPS+1];
    logic signed [CORDIC_ZW-1:0] cv_z  [CORDIC_STEPS+1];
    logic [3:0]                  cv_sb [CORDIC_STEPS+1];

    assign cv_x[0]  = {{(CORDIC_XW - ANG_BITS){1'b0}}, vn_a[NS][0][NW-1 -: ANG_BITS]};
    assign cv_y[0]  = {{(CORDIC_XW - ANG_BITS){1'b0}}, vn_a[NS][1][NW-1 -: ANG_BITS]};
    assign cv_z[0]  = '0;
    assign cv_sb[0] = vn_sb[NS];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_vcordic
        tcp_cordic_cell #(.STEP(k), .SBW(4)) u_cordic (
            .clk    (clk),
            .en     (adv),
            .x_in   (cv_x[k]),
            .y_in   (cv_y[k]),
            .z_in   (cv_z[k]),
            .sb_in  (cv_sb[k]),
            .x_out  (cv_x[k+1]),
            .y_out  (cv_y[k+1]),
            .z_out  (cv_z[k+1]),
            .sb_out (cv_sb[k+1])
        );
    end

    // v = 1/2 +/- 2*theta, rounded; a zero direction sits at one half
    vflag_t      vf_c;
    logic [30:0] v_th;
    logic [32:0] v_a;
    logic [32:0] v_sum;
    logic [F:0]  v_sph_reg;

    assign vf_c = cv_sb[CORDIC_STEPS];

    always_comb
    begin
        if (vf_c.ay_zero)
            v_th = '0;
        else if (vf_c.r_zero)
            v_th = QUARTER_TURN[30:0];
        else
            v_th = ang_clamp(cv_z[CORDIC_STEPS]);
        if (vf_c.dy_neg)
            v_a = HALF_T - {1'b0, v_th, 1'b0};
        else
            v_a = HALF_T + {1'b0, v_th, 1'b0};
        v_sum = v_a + ROUND_T;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vf_c.s_zero)
                v_sph_reg <= (F+1)'(1) << (F - 1);
            else
                v_sph_reg <= v_sum[32-F +: F+1];
        end
    end

    // ---------------- result select and output register ----------------
    function automatic logic [F:0] plan_val(input logic [F-1:0] q, input spec_t s);
        logic [F:0] r;
        case (s)
            SPEC_ZERO: r = '0;
            SPEC_ONE:  r = (F+1)'(1) << F;
            default:   r = {1'b0, q};
        endcase
        return r;
    endfunction

    plan_t      pl_last;
    logic [F:0] u_sel, v_sel, u_pl, v_pl, u_rot;
    logic       bad_sel;

    assign pl_last = pd_reg[DP-1];
    assign u_pl    = plan_val(pl_last.qu, pl_last.spec.spec_u);
    assign v_pl    = plan_val(pl_last.qv, pl_last.spec.spec_v);
    assign u_rot   = {1'b0, ud_reg[DU-1]};

    always_comb
    begin
        bad_sel = 1'b0;
        case (mode_reg)
            MODE_XY, MODE_XZ, MODE_YZ:
            begin
                u_sel = u_pl;
                v_sel = v_pl;
            end
            MODE_CYL:
            begin
                u_sel = u_rot;
                v_sel = v_pl;
            end
            MODE_SPH:
            begin
                u_sel = u_rot;
                v_sel = v_sph_reg;
            end
            default:
            begin
                u_sel   = '0;
                v_sel   = '0;
                bad_sel = 1'b1;
            end
        endcase
    end

    logic [F:0] tex_u_reg, tex_v_reg;
    logic       mode_unsupported_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= vld_reg[LS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && vld_reg[LS])
        begin
            tex_u_reg            <= u_sel;
            tex_v_reg            <= v_sel;
            mode_unsupported_reg <= bad_sel;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tex_u            = tex_u_reg;
    assign tex_v            = tex_v_reg;
    assign mode_unsupported = mode_unsupported_reg;

    // ---------------- checks ----------------
    `TCP_ASSERT_IMP(a_stall_only_full, in_stall, out_valid_reg && out_stall && vld_reg[LS], "input stalled while pipeline could move")
    `TCP_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, vld_reg[0], "accepted beat missing from first stage")
    `TCP_ASSERT_IMP(a_bad_mode_zero, out_valid_reg && mode_unsupported_reg, tex_u_reg == '0 && tex_v_reg == '0, "unsupported mode beat carries nonzero coordinates")

endmodule

// File: bench/texture_coordinate_projection_tb.sv
`timescale 1ns / 100ps

module texture_coordinate_projection_tb
    import tcp_pkg::*;
();

    localparam int CW = 32;
    localparam int FB = 16;
    // settle time after the last expected beat, with margin over the pipeline depth
    localparam int SETTLE_CYCLES = 90;
    localparam int STALL_LIMIT = 4000;
    // modes with no projection behind them
    localparam logic [2:0] MODE_RSV5 = 3'd5;
    localparam logic [2:0] MODE_RSV6 = 3'd6;
    localparam logic [2:0] MODE_RSV7 = 3'd7;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint CMAX = 64'sd2147483647;

    typedef struct {
        logic [FB:0] u;
        logic [FB:0] v;
        logic        bad;
    } uv_beat_t;

    // Holds its own copy of the registers and predicts u/v per vertex beat.
    class uv_ledger;
        logic [2:0] mode;
        longint     box[6];
        uv_beat_t   expected_uv[$];
        int         errors;
        int         checked;

        function new();
            mode = MODE_XY;
            foreach (box[i]) box[i] = 0;
            errors = 0;
            checked = 0;
        endfunction

        function longint unsigned plane_frac(longint p, longint lo, longint hi);
            longint unsigned r, den, q;
            q = 0;
            if (hi <= lo || p <= lo) return 0;
            if (p >= hi) return 64'd1 << FB;
            r = p - lo;
            den = hi - lo;
            for (int i = 0; i < FB; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q = q | 1;
                end
            end
            return q;
        endfunction

        // first-quadrant angle in 2^-32 turn, CORDIC vectoring
        function longint quad_turn(longint unsigned ax, longint unsigned ay);
            longint unsigned m;
            longint x, y, z, xs, ys;
            m = (ax > ay) ? ax : ay;
            z = 0;
            if (ay == 0) return 0;
            if (ax == 0) return longint'(QUARTER_TURN);
            while (m >= (64'd1 << 41))
            begin
                m = m >> 1; ax = ax >> 1; ay = ay >> 1;
            end
            while (m < (64'd1 << 40))
            begin
                m = m << 1; ax = ax << 1; ay = ay << 1;
            end
            x = ax;
            y = ay;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys; y = y - xs; z = z + longint'(ATAN_TURNS[i]);
                end
                else
                begin
                    x = x - ys; y = y + xs; z = z - longint'(ATAN_TURNS[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > longint'(QUARTER_TURN)) z = longint'(QUARTER_TURN);
            return z;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned mag(longint a);
            return (a < 0) ? -a : a;
        endfunction

        function longint unsigned around_u(longint dx, longint dz);
            longint ny;
            longint unsigned th, a;
            ny = -dz;
            th = quad_turn(mag(dx), mag(ny));
            if (dx >= 0 && ny >= 0) a = th;
            else if (dx < 0 && ny >= 0) a = (64'd1 << 31) - th;
            else if (dx < 0) a = (64'd1 << 31) + th;
            else a = (64'd1 << 32) - th;
            a = a & 64'hFFFF_FFFF;
            a = (a + (64'd1 << (31 - FB))) >> (32 - FB);
            return a & ((64'd1 << FB) - 1);
        endfunction

        function longint unsigned latitude_v(longint dx, longint dy, longint dz);
            longint unsigned ax, ay, az, m, r, v;
            longint th;
            ax = mag(dx); ay = mag(dy); az = mag(dz);
            m = ax;
            if (ay > m) m = ay;
            if (az > m) m = az;
            if (m == 0) return 64'd1 << (FB - 1);
            while (m >= (64'd1 << 29))
            begin
                m = m >> 1; ax = ax >> 1; ay = ay >> 1; az = az >> 1;
            end
            while (m < (64'd1 << 28))
            begin
                m = m << 1; ax = ax << 1; ay = ay << 1; az = az << 1;
            end
            r = root(ax * ax + az * az);
            th = quad_turn(r, ay);
            if (dy >= 0) v = (64'd1 << 31) + 2 * th;
            else v = (64'd1 << 31) - 2 * th;
            return (v + (64'd1 << (31 - FB))) >> (32 - FB);
        endfunction

        function void note_vertex(longint px, longint py, longint pz);
            uv_beat_t e;
            longint dx, dy, dz;
            dx = 2 * px - box[0] - box[1];
            dy = 2 * py - box[2] - box[3];
            dz = 2 * pz - box[4] - box[5];
            e.u = '0;
            e.v = '0;
            e.bad = 1'b0;
            case (mode)
                MODE_XY:
                begin
                    e.u = (FB+1)'(plane_frac(px, box[0], box[1]));
                    e.v = (FB+1)'(plane_frac(py, box[2], box[3]));
                end
                MODE_XZ:
                begin
                    e.u = (FB+1)'(plane_frac(px, box[0], box[1]));
                    e.v = (FB+1)'(plane_frac(pz, box[4], box[5]));
                end
                MODE_YZ:
                begin
                    e.u = (FB+1)'(plane_frac(pz, box[4], box[5]));
                    e.v = (FB+1)'(plane_frac(py, box[2], box[3]));
                end
                MODE_CYL:
                begin
                    e.u = (FB+1)'(around_u(dx, dz));
                    e.v = (FB+1)'(plane_frac(py, box[2], box[3]));
                end
                MODE_SPH:
                begin
                    e.u = (FB+1)'(around_u(dx, dz));
                    e.v = (FB+1)'(latitude_v(dx, dy, dz));
                end
                default: e.bad = 1'b1;
            endcase
            expected_uv.push_back(e);
        endfunction

        function void check_result(logic [FB:0] u, logic [FB:0] v, logic bad);
            uv_beat_t e;
            if (expected_uv.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (u=%0d v=%0d flag=%0b)",
                         $time, u, v, bad);
                errors++;
                return;
            end
            e = expected_uv.pop_front();
            checked++;
            if (u !== e.u)
            begin
                $display("%0t: tex_u expected %0d actual %0d", $time, e.u, u);
                errors++;
            end
            if (v !== e.v)
            begin
                $display("%0t: tex_v expected %0d actual %0d", $time, e.v, v);
                errors++;
            end
            if (bad !== e.bad)
            begin
                $display("%0t: mode_unsupported expected %0b actual %0b",
                         $time, e.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [2:0]           cfg_index;
    logic [CW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic                 out_valid;
    logic                 out_stall;
    logic [FB:0]          tex_u;
    logic [FB:0]          tex_v;
    logic                 mode_unsupported;

    uv_ledger ledger;
    bit       quiet;      // no idling on either side while set
    int       idle_cycles;
    int       sent;
    int       phases;

    texture_coordinate_projection uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tex_u           (tex_u),
        .tex_v           (tex_v),
        .mode_unsupported(mode_unsupported)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic bit take_break();
        return !quiet && ($urandom_range(0, 99) < 15);
    endfunction

    // receiver: random stall, changed on the falling edge
    always @(negedge clk)
    begin
        out_stall <= take_break();
    end

    // result beats are checked on the rising edge they are taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(tex_u, tex_v, mode_unsupported);
    end

    // watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no beat moved for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One vertex beat; valid stays up between back-to-back beats.
    task automatic send_vertex(longint px, longint py, longint pz);
        @(negedge clk);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= px[CW-1:0];
        pos_y <= py[CW-1:0];
        pos_z <= pz[CW-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        ledger.note_vertex(longint'(signed'(px[CW-1:0])),
                           longint'(signed'(py[CW-1:0])),
                           longint'(signed'(pz[CW-1:0])));
        sent++;
    endtask

    // sender holds off until every expected beat is back, then lets the
    // pipeline empty (cylindrical/spherical beats are long in flight)
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.expected_uv.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CW-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MODE) ledger.mode = value[2:0];
        else ledger.box[idx - 1] = longint'(signed'(value[CW-1:0]));
    endtask

    task automatic set_projection(logic [2:0] mode, longint x0, longint x1,
                                  longint y0, longint y1, longint z0, longint z1);
        drain();
        write_reg(REG_MODE, mode);
        write_reg(REG_MIN_X, x0);
        write_reg(REG_MAX_X, x1);
        write_reg(REG_MIN_Y, y0);
        write_reg(REG_MAX_Y, y1);
        write_reg(REG_MIN_Z, z0);
        write_reg(REG_MAX_Z, z1);
        phases++;
    endtask

    function automatic longint clamp32(longint a);
        if (a < CMIN) return CMIN;
        if (a > CMAX) return CMAX;
        return a;
    endfunction

    // Coordinate on one axis: mostly near the box, some full-range noise,
    // some extremes and the exact center (zero direction).
    function automatic longint pick_coord(longint lo, longint hi);
        longint span, base;
        longint unsigned r;
        r = {$urandom, $urandom};
        span = (hi > lo) ? hi - lo : 64'sd4096;
        base = (hi > lo) ? lo : lo - 2048;
        case ($urandom_range(0, 11))
            0, 1: return longint'(signed'($urandom));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return CMIN;
                    1: return CMAX;
                    2: return lo;
                    default: return hi;
                endcase
            end
            3: return (lo + hi) >>> 1;
            default: return clamp32(base - span / 8 + longint'(r % (span + span / 4 + 1)));
        endcase
    endfunction

    task automatic random_vertices(int n);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(ledger.box[0], ledger.box[1]),
                        pick_coord(ledger.box[2], ledger.box[3]),
                        pick_coord(ledger.box[4], ledger.box[5]));
    endtask

    // corners, just outside, center, and unit steps off the center
    task automatic directed_vertices();
        longint cx, cy, cz;
        cx = (ledger.box[0] + ledger.box[1]) >>> 1;
        cy = (ledger.box[2] + ledger.box[3]) >>> 1;
        cz = (ledger.box[4] + ledger.box[5]) >>> 1;
        send_vertex(cx, cy, cz);
        send_vertex(ledger.box[0], ledger.box[2], ledger.box[4]);
        send_vertex(ledger.box[1], ledger.box[3], ledger.box[5]);
        send_vertex(ledger.box[0] - 1, ledger.box[2] - 1, ledger.box[4] - 1);
        send_vertex(ledger.box[1] + 1, ledger.box[3] + 1, ledger.box[5] + 1);
        send_vertex(cx - 1, cy, cz);
        send_vertex(cx + 1, cy, cz);
        send_vertex(cx, cy, cz + 1);
        send_vertex(cx, cy + 1, cz);
        send_vertex(cx, cy - 1, cz);
        send_vertex(CMIN, CMIN, CMIN);
        send_vertex(CMAX, CMAX, CMAX);
    endtask

    function automatic longint pick_bound();
        case ($urandom_range(0, 3))
            0: return longint'(signed'($urandom));
            1: return longint'(signed'($urandom_range(0, 32'h00FF_FFFF))) - 64'sd8388608;
            default: return longint'(signed'($urandom_range(0, 32'h0003_FFFF))) - 64'sd131072;
        endcase
    endfunction

    initial
    begin
        longint lo_x, lo_y, lo_z, ext;
        logic [2:0] m;
        ledger = new();
        quiet = 1'b0;
        sent = 0;
        phases = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: XY over an empty box, every planar result is zero
        random_vertices(20);

        // planar box of +-10.0 with an odd Z extent
        set_projection(MODE_XY, -655360, 655360, -655360, 655360, -3, 65536);
        directed_vertices();
        random_vertices(30);

        // spherical around an off-origin center
        set_projection(MODE_SPH, -131072, 262144, -65536, 65536, -262144, 131072);
        directed_vertices();
        random_vertices(40);

        // register extremes and degenerate extents
        set_projection(MODE_XZ, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
        random_vertices(30);
        set_projection(MODE_YZ, CMAX, CMIN, 100, 100, CMAX, CMIN);
        random_vertices(30);
        set_projection(MODE_CYL, 0, 0, CMIN, CMAX, 0, 0);
        random_vertices(30);
        set_projection(MODE_SPH, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
        random_vertices(30);
        set_projection(MODE_RSV5, -65536, 65536, -65536, 65536, -65536, 65536);
        random_vertices(15);
        set_projection(MODE_RSV6, 0, 1, 0, 1, 0, 1);
        random_vertices(15);
        set_projection(MODE_RSV7, CMIN, CMAX, 0, 0, CMAX, CMIN);
        random_vertices(15);

        // random boxes and modes; a run of phases with no idling at all
        for (int p = 0; p < 22; p++)
        begin
            quiet = (p >= 8 && p < 12);
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            lo_x = pick_bound();
            lo_y = pick_bound();
            lo_z = pick_bound();
            ext = longint'($urandom_range(0, 32'h0010_0000));
            set_projection(m, lo_x, clamp32(lo_x + ext),
                           lo_y, ($urandom_range(0, 7) == 0) ? lo_y - 1 : clamp32(lo_y + ext),
                           lo_z, clamp32(lo_z + longint'($urandom_range(0, 32'h0008_0000))));
            random_vertices(48);
        end
        quiet = 1'b0;

        drain();
        $display("Sent %0d vertex beats over %0d register settings, %0d results checked.",
                 sent, phases, ledger.checked);
        $display("Modes XY/XZ/YZ/cylindrical/spherical/reserved, extreme and empty boxes.");
        if (ledger.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tcp_pkg.sv
rtl/tcp_div_cell.sv
rtl/tcp_norm_cell.sv
rtl/tcp_cordic_cell.sv
rtl/tcp_sqrt_cell.sv
rtl/texture_coordinate_projection.sv
bench/texture_coordinate_projection_tb.sv
